### rtl/core/swm_pkg.sv
// Shared types and constants for the sliding window maximum unit.
package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int WIN_W    = 7;
  localparam int SEEN_W   = 16;
  localparam int AGE_W    = 15;
  localparam int ENTRY_W  = SAMPLE_W + AGE_W;

  localparam logic [WIN_W-1:0]  WIN_RESET = WIN_W'(3);
  localparam logic [SEEN_W-1:0] SEEN_WRAP = SEEN_W'(16'h8000);
  localparam logic [SEEN_W-1:0] SEEN_TOP  = SEEN_W'(16'hFFFF);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_BACK   = 4'b0010,
    S_APPEND = 4'b0100,
    S_FRONT  = 4'b1000
  } swm_state_t;

endpackage

### rtl/core/sliding_window_maximum_unit.sv
// Sliding window maximum over a signed sample stream, monotonic queue in a RAM.
//
// Input channel (in_valid/in_ready): one signed sample and a last flag per item.
// Result channel (out_valid/out_ready): window maximum and stream_end flag.
// Configuration: cfg_wr_en writes cfg_wr_data as the window size (0 acts as 1,
// sizes above MAX_WINDOW act as MAX_WINDOW); write only while the block is idle.
// Each item walks a small sequencer around one signed comparator and one
// single-port-read queue RAM: it is accepted, the candidates at the back are
// examined one at a time, the item is appended, and the candidates expired at
// the front are dropped one at a time before the item finishes. in_ready is
// low meanwhile, so no new item is taken until the last one is through.
// A result appears once the window has filled, or on a last item before that;
// after a last item all stream state clears.
// The result sits in an output register; the next item is accepted while it
// waits, and the sequencer holds at its final step only if a second result is
// ready before the first is taken.
// Reset (rst_n low, synchronous) empties the queue, zeroes the sample count,
// drops any pending result and sets the window size to 3.
module sliding_window_maximum_unit
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_max_value,
  output logic                       out_stream_end,
  input  logic                       cfg_wr_en,
  input  logic [WIN_W-1:0]           cfg_wr_data
);

  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_WINDOW - 1);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_WINDOW);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_LAST : p - PTR_W'(1);
  endfunction

  logic [ENTRY_W-1:0] mem [MAX_WINDOW];

  swm_state_t                 state_r, state_nxt;
  logic signed [SAMPLE_W-1:0] val_r, val_nxt;
  logic                       last_r, last_nxt;
  logic [SEEN_W-1:0]          cur_r, cur_nxt;
  logic [WIN_W-1:0]           win_r, win_nxt;
  logic [WIN_W-1:0]           cfg_win_r;
  logic [PTR_W-1:0]           head_r, head_nxt;
  logic [PTR_W-1:0]           tail_r, tail_nxt;
  logic [LEN_W-1:0]           len_r, len_nxt;
  logic [SEEN_W-1:0]          seen_r, seen_nxt;
  logic [ENTRY_W-1:0]         rd_data_r;
  logic signed [SAMPLE_W-1:0] out_max_r, out_max_nxt;
  logic                       out_end_r, out_end_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic [PTR_W-1:0]           rd_addr;
  logic                       wr_en;
  logic [PTR_W-1:0]           wr_addr;
  logic [ENTRY_W-1:0]         wr_data;
  logic [WIN_W-1:0]           win_clamped;
  logic signed [SAMPLE_W-1:0] rd_val;
  logic [AGE_W-1:0]           rd_pos;
  logic signed [SAMPLE_W-1:0] front_val;
  logic [AGE_W-1:0]           front_pos;
  logic [AGE_W-1:0]           age;
  logic                       cmp_le;
  logic                       filled;
  logic                       emit;
  logic [PTR_W-1:0]           head_app;

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_max_value  = out_max_r;
  assign out_stream_end = out_end_r;

  always_comb begin
    if (cfg_win_r == '0) begin
      win_clamped = WIN_W'(1);
    end else if (int'(cfg_win_r) > MAX_WINDOW) begin
      win_clamped = WIN_W'(MAX_WINDOW);
    end else begin
      win_clamped = cfg_win_r;
    end
  end

  assign rd_val    = $signed(rd_data_r[ENTRY_W-1:AGE_W]);
  assign rd_pos    = rd_data_r[AGE_W-1:0];
  assign cmp_le    = (rd_val <= val_r);
  assign front_val = (len_r == LEN_W'(1)) ? val_r : rd_val;
  assign front_pos = (len_r == LEN_W'(1)) ? cur_r[AGE_W-1:0] : rd_pos;
  assign age       = cur_r[AGE_W-1:0] - front_pos;
  assign filled    = cur_r[SEEN_W-1] ||
                     ({1'b0, cur_r} + (SEEN_W+1)'(1) >= (SEEN_W+1)'(win_r));
  assign emit      = filled || last_r;
  assign head_app  = (len_r == LEN_FULL) ? ptr_inc(head_r) : head_r;

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    cur_nxt       = cur_r;
    win_nxt       = win_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    len_nxt       = len_r;
    seen_nxt      = seen_r;
    out_max_nxt   = out_max_r;
    out_end_nxt   = out_end_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_addr       = head_r;
    wr_en         = 1'b0;
    wr_addr       = tail_r;
    wr_data       = {val_r, cur_r[AGE_W-1:0]};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt  = in_sample;
          last_nxt = in_last;
          cur_nxt  = seen_r;
          win_nxt  = win_clamped;
          if (len_r != '0) begin
            rd_addr   = ptr_dec(tail_r);
            state_nxt = S_BACK;
          end else begin
            state_nxt = S_APPEND;
          end
        end
      end
      S_BACK: begin
        if (cmp_le) begin
          tail_nxt = ptr_dec(tail_r);
          len_nxt  = len_r - LEN_W'(1);
          if (len_r != LEN_W'(1)) begin
            rd_addr = ptr_dec(ptr_dec(tail_r));
          end else begin
            state_nxt = S_APPEND;
          end
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        wr_en    = 1'b1;
        tail_nxt = ptr_inc(tail_r);
        head_nxt = head_app;
        rd_addr  = head_app;
        if (len_r != LEN_FULL) begin
          len_nxt = len_r + LEN_W'(1);
        end
        state_nxt = S_FRONT;
      end
      S_FRONT: begin
        if (age >= AGE_W'(win_r)) begin
          head_nxt = ptr_inc(head_r);
          len_nxt  = len_r - LEN_W'(1);
          rd_addr  = ptr_inc(head_r);
        end else if (!(emit && out_valid_r && !out_ready)) begin
          if (emit) begin
            out_max_nxt   = front_val;
            out_end_nxt   = last_r;
            out_valid_nxt = 1'b1;
          end
          if (last_r) begin
            len_nxt  = '0;
            head_nxt = '0;
            tail_nxt = '0;
            seen_nxt = '0;
          end else if (cur_r == SEEN_TOP) begin
            seen_nxt = SEEN_WRAP;
          end else begin
            seen_nxt = cur_r + SEEN_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      len_r       <= '0;
      seen_r      <= '0;
      cfg_win_r   <= WIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      len_r       <= len_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_win_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    last_r    <= last_nxt;
    cur_r     <= cur_nxt;
    win_r     <= win_nxt;
    out_max_r <= out_max_nxt;
    out_end_r <= out_end_nxt;
  end

endmodule

### rtl/core/swm_checker.sv
// Port-level checks for the sliding window maximum unit, bound to the top level.
module swm_checker
  import swm_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_max_value,
  input logic                       out_stream_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_max_value) &&
                                $stable(out_stream_end))
    else $error("result changed or dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted in back-to-back cycles");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without an item in progress");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind sliding_window_maximum_unit swm_checker u_swm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_max_value  (out_max_value),
  .out_stream_end (out_stream_end)
);

### tb/tb_top.sv
// Testbench for the sliding window maximum unit: directed table, random streams, final stream.
`timescale 1ns / 100ps

module tb_top
  import swm_pkg::*;
();

  localparam int MAX_WIN      = 64;
  localparam int DRAIN_CYCLES = 160;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 120;
  localparam int LONG_LEN     = 200;
  localparam int EXP_DEPTH    = 64;

  localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh80000000;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFFFFFF;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PRED,
    ROW_NONE,
    ROW_RES
  } row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [WIN_W-1:0]            win;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        last;
    logic signed [SAMPLE_W-1:0]  exp_max;
    logic                        exp_end;
  } row_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] max_value;
    logic                       stream_end;
  } max_rec_t;

  localparam int NUM_DIR = 29;
  localparam row_t DIR_TAB [NUM_DIR] = '{
    '{ROW_RES,  7'd0,   32'sd5,          1'b1, 32'sd5,  1'b1},
    '{ROW_NONE, 7'd0,   S_MIN,           1'b0, 32'sd0,  1'b0},
    '{ROW_NONE, 7'd0,   S_MAX,           1'b0, 32'sd0,  1'b0},
    '{ROW_RES,  7'd0,   -32'sd1,         1'b0, S_MAX,   1'b0},
    '{ROW_RES,  7'd0,   32'sd0,          1'b0, S_MAX,   1'b0},
    '{ROW_RES,  7'd0,   32'sd0,          1'b0, 32'sd0,  1'b0},
    '{ROW_RES,  7'd0,   -32'sd7,         1'b1, 32'sd0,  1'b1},
    '{ROW_CFG,  7'd0,   32'sd0,          1'b0, 32'sd0,  1'b0},
    '{ROW_RES,  7'd0,   S_MIN,           1'b0, S_MIN,   1'b0},
    '{ROW_RES,  7'd0,   32'sd12,         1'b1, 32'sd12, 1'b1},
    '{ROW_CFG,  7'd127, 32'sd0,          1'b0, 32'sd0,  1'b0},
    '{ROW_NONE, 7'd0,   32'sd3,          1'b0, 32'sd0,  1'b0},
    '{ROW_RES,  7'd0,   -32'sd3,         1'b1, 32'sd3,  1'b1},
    '{ROW_CFG,  7'd4,   32'sd0,          1'b0, 32'sd0,  1'b0},
    '{ROW_NONE, 7'd0,   32'sd9,          1'b0, 32'sd0,  1'b0},
    '{ROW_NONE, 7'd0,   32'sd8,          1'b0, 32'sd0,  1'b0},
    '{ROW_NONE, 7'd0,   32'sd7,          1'b0, 32'sd0,  1'b0},
    '{ROW_RES,  7'd0,   32'sd6,          1'b0, 32'sd9,  1'b0},
    '{ROW_CFG,  7'd2,   32'sd0,          1'b0, 32'sd0,  1'b0},
    '{ROW_RES,  7'd0,   32'sd1,          1'b0, 32'sd6,  1'b0},
    '{ROW_PRED, 7'd0,   32'sd5,          1'b0, 32'sd0,  1'b0},
    '{ROW_CFG,  7'd64,  32'sd0,          1'b0, 32'sd0,  1'b0},
    '{ROW_PRED, 7'd0,   -32'sd2,         1'b0, 32'sd0,  1'b0},
    '{ROW_PRED, 7'd0,   32'sd100,        1'b1, 32'sd0,  1'b0},
    '{ROW_CFG,  7'd65,  32'sd0,          1'b0, 32'sd0,  1'b0},
    '{ROW_PRED, 7'd0,   32'sh55555555,   1'b0, 32'sd0,  1'b0},
    '{ROW_PRED, 7'd0,   32'shAAAAAAAA,   1'b1, 32'sd0,  1'b0},
    '{ROW_CFG,  7'd1,   32'sd0,          1'b0, 32'sd0,  1'b0},
    '{ROW_PRED, 7'd0,   -32'sd1,         1'b1, 32'sd0,  1'b0}
  };

  localparam logic [WIN_W-1:0] WIN_PICK [8] = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd63, 7'd64, 7'd65,
                                                7'd127};

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       in_last = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_max_value;
  logic                       out_stream_end;
  logic                       cfg_wr_en = 1'b0;
  logic [WIN_W-1:0]           cfg_wr_data = '0;

  logic signed [SAMPLE_W-1:0] cand_val [MAX_WIN];
  logic [SEEN_W-1:0]          cand_pos [MAX_WIN];
  int                         cand_cnt = 0;
  logic [SEEN_W-1:0]          seen_cnt = '0;
  logic [WIN_W-1:0]           win_reg = WIN_RESET;

  max_rec_t                   exp_fifo [EXP_DEPTH];
  int                         exp_wr = 0;
  int                         exp_rd = 0;
  max_rec_t                   head_rec;
  int                         errors = 0;
  bit                         idle_on = 1'b0;
  int                         hold_cnt = 0;
  int                         run_left = 0;
  int                         run_mode = 0;
  logic signed [SAMPLE_W-1:0] ramp = '0;

  sliding_window_maximum_unit #(
    .MAX_WINDOW(MAX_WIN)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_max_value (out_max_value),
    .out_stream_end(out_stream_end),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void queue_expect(input max_rec_t rec);
    exp_fifo[exp_wr % EXP_DEPTH] = rec;
    exp_wr++;
  endfunction

  function automatic int span_of(input logic [WIN_W-1:0] w);
    int s;
    s = int'(w);
    if (s == 0) s = 1;
    if (s > MAX_WIN) s = MAX_WIN;
    return s;
  endfunction

  function automatic void shift_front(input int n);
    if (n == 0 || n > cand_cnt) return;
    for (int i = 0; i + n < cand_cnt; i++) begin
      cand_val[i] = cand_val[i + n];
      cand_pos[i] = cand_pos[i + n];
    end
    cand_cnt -= n;
  endfunction

  function automatic bit track_window_max(input logic signed [SAMPLE_W-1:0] val,
                                          input logic fin,
                                          output logic signed [SAMPLE_W-1:0] top);
    int                span;
    int                drop;
    logic [SEEN_W-1:0] cur;
    bit                emit;
    span = span_of(win_reg);
    cur  = seen_cnt;
    while (cand_cnt > 0 && cand_val[cand_cnt - 1] <= val) cand_cnt--;
    if (cand_cnt >= MAX_WIN) shift_front(1);
    cand_val[cand_cnt] = val;
    cand_pos[cand_cnt] = cur;
    cand_cnt++;
    drop = 0;
    while (drop < cand_cnt && int'(AGE_W'(cur - cand_pos[drop])) >= span) drop++;
    shift_front(drop);
    seen_cnt = (cur == SEEN_TOP) ? SEEN_WRAP : cur + 1'b1;
    emit = (cur >= SEEN_WRAP) || (int'(cur) + 1 >= span) || fin;
    top  = cand_val[0];
    if (fin) begin
      cand_cnt = 0;
      seen_cnt = '0;
    end
    return emit;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    case (run_mode)
      0: return $urandom;
      1: return $signed(32'($urandom_range(0, 8))) - 32'sd4;
      2: begin
        ramp = ramp - $signed(32'($urandom_range(0, 3)));
        return ramp;
      end
      3: begin
        ramp = ramp + $signed(32'($urandom_range(0, 3)));
        return ramp;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return S_MIN;
          1: return S_MAX;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
    endcase
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic l);
    in_valid  <= 1'b1;
    in_sample <= s;
    in_last   <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic apply_item(input logic signed [SAMPLE_W-1:0] s, input logic l,
                            input row_kind_t kind,
                            input logic signed [SAMPLE_W-1:0] exp_max, input logic exp_end);
    logic signed [SAMPLE_W-1:0] top;
    bit                         hit;
    send_sample(s, l);
    hit = track_window_max(s, l, top);
    if (kind == ROW_RES) queue_expect(max_rec_t'{exp_max, exp_end});
    else if (kind == ROW_PRED && hit) queue_expect(max_rec_t'{top, l});
  endtask

  task automatic pace_sender();
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic set_window(input logic [WIN_W-1:0] w);
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_reg = w;
  endtask

  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      hold_cnt  <= $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (exp_wr == exp_rd) begin
        $error("unexpected result: max_value %0d stream_end %0b", out_max_value, out_stream_end);
        errors++;
      end else begin
        head_rec = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_max_value !== head_rec.max_value) begin
          $error("max_value: expected %0d, got %0d", head_rec.max_value, out_max_value);
          errors++;
        end
        if (out_stream_end !== head_rec.stream_end) begin
          $error("stream_end: expected %0b, got %0b", head_rec.stream_end, out_stream_end);
          errors++;
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [WIN_W-1:0]           wv;
    logic signed [SAMPLE_W-1:0] s;
    int                         eff;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_DIR; r++) begin
      if (DIR_TAB[r].kind == ROW_CFG) begin
        set_window(DIR_TAB[r].win);
      end else begin
        apply_item(DIR_TAB[r].sample, DIR_TAB[r].last, DIR_TAB[r].kind,
                   DIR_TAB[r].exp_max, DIR_TAB[r].exp_end);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 8) wv = WIN_PICK[ph];
      else wv = WIN_W'($urandom_range(1, MAX_WIN));
      set_window(wv);
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) begin
        if (run_left == 0) begin
          eff      = span_of(wv);
          run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, eff)
                                                 : $urandom_range(eff, 3 * eff + 4);
          run_mode = $urandom_range(0, 4);
          ramp     = $urandom;
        end
        s = draw_sample();
        run_left--;
        apply_item(s, run_left == 0, ROW_PRED, '0, 1'b0);
        pace_sender();
      end
    end

    // finish with one stream, no idling
    set_window(7'd5);
    idle_on = 1'b0;
    for (int k = 0; k < LONG_LEN; k++) begin
      s = $signed(32'($urandom_range(0, 30))) - 32'sd15;
      apply_item(s, k == LONG_LEN - 1, ROW_PRED, '0, 1'b0);
    end

    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/swm_pkg.sv
rtl/core/sliding_window_maximum_unit.sv
rtl/core/swm_checker.sv
tb/tb_top.sv
